// ===== sv/nmea_sentence_checker_macros.svh =====
// Assertion macros shared by the sentence checker RTL.
`ifndef NMEA_SENTENCE_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define NSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define NSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nsc_pkg.sv =====
// Package with the constants, codes and helper functions of the sentence checker.
package nsc_pkg;

  localparam int unsigned TableSize = 7;
  localparam int unsigned IdCountDefault = 7;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharLineFeed = 8'h0A;
  localparam logic [7:0] CharZero = 8'h00;

  localparam logic [2:0] TargetTypeReset = 3'd1;
  localparam logic [15:0] TryLimitReset = 16'd0;
  localparam logic [7:0] MaxLengthReset = 8'd128;

  localparam logic [23:0] IdTable [TableSize] = '{
    {8'h47, 8'h47, 8'h41},
    {8'h47, 8'h4C, 8'h4C},
    {8'h47, 8'h53, 8'h41},
    {8'h47, 8'h53, 8'h56},
    {8'h52, 8'h4D, 8'h43},
    {8'h56, 8'h54, 8'h47},
    {8'h5A, 8'h44, 8'h41}
  };

  typedef enum logic [1:0] {
    STAT_SEARCHING = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_BAD_SUM   = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } search_status_t;

  typedef enum logic [1:0] {
    REG_TARGET_TYPE = 2'd0,
    REG_TRY_LIMIT   = 2'd1,
    REG_MAX_LENGTH  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.value = 4'(c - 8'h57);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== sv/nmea_sentence_checker.sv =====
// NMEA sentence checker: one received byte per item, one result per sentence end.
// For each item the byte is decoded against the sentence state and, when it
// closes a sentence, the type, checksum verdict, search status and length are loaded into
// the result register in the same cycle; a new byte is accepted every cycle while that
// register is empty or being emptied. Configuration is an APB-style port with target_type
// at 0x0, try_limit at 0x4 and max_length at 0x8.
module nmea_sentence_checker #(
  parameter int unsigned ID_COUNT = nsc_pkg::IdCountDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_sentence_type,
  output logic        out_checksum_ok,
  output logic [1:0]  out_search_status,
  output logic [7:0]  out_sentence_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nsc_pkg::*;

  `include "nmea_sentence_checker_macros.svh"

  localparam int unsigned ActiveIds = (ID_COUNT < TableSize) ? ID_COUNT : TableSize;

  logic [2:0]  target_type_r;
  logic [15:0] try_limit_r;
  logic [7:0]  max_length_r;

  logic                 in_sentence_r, in_sentence_nxt;
  logic [7:0]           byte_count_r, byte_count_nxt;
  logic [7:0]           running_xor_r, running_xor_nxt;
  logic                 star_seen_r, star_seen_nxt;
  logic [1:0]           hex_count_r, hex_count_nxt;
  logic                 hex_stopped_r, hex_stopped_nxt;
  logic [7:0]           received_sum_r, received_sum_nxt;
  logic [15:0]          prev_chars_r, prev_chars_nxt;
  logic [ActiveIds-1:0] id_flags_r, id_flags_nxt;
  logic [15:0]          tries_left_r, tries_left_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_type_r;
  logic                 out_ok_r;
  search_status_t       out_status_r;
  logic [7:0]           out_length_r;

  logic           accept;
  logic           sentence_end;
  logic [2:0]     type_c;
  logic           ok_c;
  search_status_t status_c;
  hex_digit_t     hex_c;
  reg_index_t     cfg_index;
  logic           cfg_write;

  assign pready = 1'b1;
  assign cfg_index = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_index)
      REG_TARGET_TYPE: prdata = {29'd0, target_type_r};
      REG_TRY_LIMIT:   prdata = {16'd0, try_limit_r};
      REG_MAX_LENGTH:  prdata = {24'd0, max_length_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_type_r <= TargetTypeReset;
      try_limit_r <= TryLimitReset;
      max_length_r <= MaxLengthReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARGET_TYPE: target_type_r <= pwdata[2:0];
        REG_TRY_LIMIT:   try_limit_r <= pwdata[15:0];
        REG_MAX_LENGTH:  max_length_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    in_sentence_nxt = in_sentence_r;
    byte_count_nxt = byte_count_r;
    running_xor_nxt = running_xor_r;
    star_seen_nxt = star_seen_r;
    hex_count_nxt = hex_count_r;
    hex_stopped_nxt = hex_stopped_r;
    received_sum_nxt = received_sum_r;
    prev_chars_nxt = prev_chars_r;
    id_flags_nxt = id_flags_r;
    tries_left_nxt = tries_left_r;
    sentence_end = 1'b0;
    type_c = 3'd0;
    ok_c = 1'b0;
    status_c = STAT_SEARCHING;
    hex_c = hex_decode(in_rx_byte);

    if (in_rx_byte == CharDollar) begin
      in_sentence_nxt = 1'b1;
      byte_count_nxt = 8'd1;
      running_xor_nxt = 8'd0;
      star_seen_nxt = 1'b0;
      hex_count_nxt = 2'd0;
      hex_stopped_nxt = 1'b0;
      received_sum_nxt = 8'd0;
      prev_chars_nxt = {8'h00, CharDollar};
      id_flags_nxt = '0;
    end else if (in_sentence_r) begin
      byte_count_nxt = byte_count_r + 8'd1;
      if (in_rx_byte != CharZero) begin
        if (!star_seen_r) begin
          if (in_rx_byte == CharStar) begin
            star_seen_nxt = 1'b1;
          end else begin
            running_xor_nxt = running_xor_r ^ in_rx_byte;
          end
        end else if (!hex_stopped_r && hex_count_r < 2'd2) begin
          if (!hex_c.valid) begin
            hex_stopped_nxt = 1'b1;
          end else begin
            received_sum_nxt = {received_sum_r[3:0], hex_c.value};
            hex_count_nxt = hex_count_r + 2'd1;
          end
        end
        if (byte_count_nxt >= 8'd3) begin
          for (int i = 0; i < ActiveIds; i++) begin
            if ({prev_chars_r, in_rx_byte} == IdTable[i]) begin
              id_flags_nxt[i] = 1'b1;
            end
          end
        end
        prev_chars_nxt = {prev_chars_r[7:0], in_rx_byte};
      end
    end

    if (in_rx_byte == CharDollar || in_sentence_r) begin
      sentence_end = (in_rx_byte == CharLineFeed) || (in_rx_byte == CharZero) ||
                     (byte_count_nxt >= max_length_r);
    end

    if (sentence_end) begin
      in_sentence_nxt = 1'b0;
      for (int i = ActiveIds - 1; i >= 0; i--) begin
        if (id_flags_nxt[i]) begin
          type_c = 3'(i + 1);
        end
      end
      ok_c = star_seen_nxt && (hex_count_nxt != 2'd0) && (received_sum_nxt == running_xor_nxt);
      priority if (!ok_c) begin
        status_c = STAT_BAD_SUM;
      end else if (type_c == target_type_r) begin
        status_c = STAT_FOUND;
      end else if (tries_left_r != 16'd0) begin
        tries_left_nxt = tries_left_r - 16'd1;
        status_c = (tries_left_nxt == 16'd0) ? STAT_EXHAUSTED : STAT_SEARCHING;
      end else begin
        status_c = STAT_SEARCHING;
      end
      if (status_c != STAT_SEARCHING) begin
        tries_left_nxt = try_limit_r;
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || (accept && sentence_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      byte_count_r <= 8'd0;
      running_xor_r <= 8'd0;
      star_seen_r <= 1'b0;
      hex_count_r <= 2'd0;
      hex_stopped_r <= 1'b0;
      received_sum_r <= 8'd0;
      prev_chars_r <= 16'd0;
      id_flags_r <= '0;
      tries_left_r <= TryLimitReset;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        in_sentence_r <= in_sentence_nxt;
        byte_count_r <= byte_count_nxt;
        running_xor_r <= running_xor_nxt;
        star_seen_r <= star_seen_nxt;
        hex_count_r <= hex_count_nxt;
        hex_stopped_r <= hex_stopped_nxt;
        received_sum_r <= received_sum_nxt;
        prev_chars_r <= prev_chars_nxt;
        id_flags_r <= id_flags_nxt;
        tries_left_r <= tries_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sentence_end) begin
      out_type_r <= type_c;
      out_ok_r <= ok_c;
      out_status_r <= status_c;
      out_length_r <= byte_count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_sentence_type = out_type_r;
  assign out_checksum_ok = out_ok_r;
  assign out_search_status = out_status_r;
  assign out_sentence_length = out_length_r;

  `NSC_ASSERT_NEXT(a_result_loaded, accept && sentence_end,
    out_valid_r && out_length_r == $past(byte_count_nxt), "Sentence end did not load a result.")
  `NSC_ASSERT_NOW(a_open_has_length, in_sentence_r, byte_count_r != 8'd0,
    "An open sentence has no stored bytes.")
  `NSC_ASSERT_NOW(a_status_needs_ok, out_valid_r && out_status_r != STAT_BAD_SUM,
    out_ok_r, "A search status other than checksum failed came with a bad checksum.")
  `NSC_ASSERT_NOW(a_hex_after_star, hex_count_r != 2'd0, star_seen_r && hex_count_r != 2'd3,
    "Hex digits were counted without a star or beyond two.")

endmodule
